// ===== design/atrc_pkg.sv =====
`timescale 1ns / 1ps

package atrc_pkg;

   localparam int BufferDepth = 4096;
   localparam int AddrWidth   = $clog2(BufferDepth);
   localparam int CountWidth  = $clog2(BufferDepth + 1);

   localparam int ByteCountWidth = 13;
   localparam int IndexWidth     = 12;
   localparam int TimeoutWidth   = 16;

   localparam logic [7:0] CharLf = 8'h0A;
   localparam logic [7:0] CharCr = 8'h0D;
   localparam logic [7:0] CharO  = 8'h4F;
   localparam logic [7:0] CharK  = 8'h4B;
   localparam logic [7:0] CharE  = 8'h45;
   localparam logic [7:0] CharR  = 8'h52;

   typedef enum logic [1:0] {
      ActArm  = 2'd0,
      ActByte = 2'd1,
      ActTick = 2'd2,
      ActRead = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      StOk    = 2'd0,
      StError = 2'd1,
      StFail  = 2'd2
   } status_type;

   // Result of one item, minus the buffer read data that arrives from the RAM
   typedef struct packed {
      logic                  busy;
      status_type            status;
      logic                  done;
      logic [CountWidth-1:0] count;
      logic                  rd_valid;
   } result_type;

   typedef struct packed {
      logic                 en;
      logic [AddrWidth-1:0] addr;
      logic [7:0]           data;
   } wr_port_type;

   typedef struct packed {
      logic                 en;
      logic [AddrWidth-1:0] addr;
   } rd_port_type;

endpackage

// ===== design/atrc_buffer.sv =====
`timescale 1ns / 1ps

module atrc_buffer (
   input  logic                  clock,
   input  atrc_pkg::wr_port_type wr,
   input  atrc_pkg::rd_port_type rd,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [atrc_pkg::BufferDepth];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read data holds until the next read, so a stalled result keeps its byte
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/atrc_ctrl.sv =====
`timescale 1ns / 1ps

module atrc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  atrc_pkg::action_type                action,
   input  logic [7:0]                          rx_byte,
   input  logic [atrc_pkg::TimeoutWidth-1:0]   timeout_ticks,
   input  logic [atrc_pkg::IndexWidth-1:0]     read_index,
   output atrc_pkg::result_type                result,
   output atrc_pkg::wr_port_type               wr,
   output atrc_pkg::rd_port_type               rd
);

   logic [47:0]                           recent_ff, recent_in;
   logic [atrc_pkg::CountWidth-1:0]       count_ff, count_in;
   logic                                  collecting_ff, collecting_in;
   atrc_pkg::status_type                  status_ff, status_in;
   logic [atrc_pkg::TimeoutWidth-1:0]     ticks_ff, ticks_in, ticks_dec;
   logic                                  done;
   logic                                  full;
   logic                                  crlf, ok_seen, error_seen;

   assign full = (32'(count_ff) >= 32'(atrc_pkg::BufferDepth));
   assign ticks_dec = (ticks_ff == '0) ? '0 : ticks_ff - 1'b1;

   // recent_ff[7:0] is the byte stored just before the incoming one
   assign crlf = (rx_byte == atrc_pkg::CharLf) && (count_ff >= 1)
      && (recent_ff[7:0] == atrc_pkg::CharCr);
   assign ok_seen = crlf && (count_ff >= 3)
      && (recent_ff[23:16] == atrc_pkg::CharO) && (recent_ff[15:8] == atrc_pkg::CharK);
   assign error_seen = crlf && (count_ff >= 6)
      && (recent_ff[47:40] == atrc_pkg::CharE) && (recent_ff[39:32] == atrc_pkg::CharR)
      && (recent_ff[31:24] == atrc_pkg::CharR) && (recent_ff[23:16] == atrc_pkg::CharO)
      && (recent_ff[15:8] == atrc_pkg::CharR);

   always_comb begin
      recent_in     = recent_ff;
      count_in      = count_ff;
      collecting_in = collecting_ff;
      status_in     = status_ff;
      ticks_in      = ticks_ff;
      done          = 1'b0;
      wr.en         = 1'b0;
      wr.addr       = count_ff[atrc_pkg::AddrWidth-1:0];
      wr.data       = rx_byte;
      unique case (action)
         atrc_pkg::ActArm: begin
            recent_in     = '0;
            count_in      = '0;
            status_in     = atrc_pkg::StFail;
            ticks_in      = timeout_ticks;
            collecting_in = (timeout_ticks != '0);
            done          = (timeout_ticks == '0);
         end
         atrc_pkg::ActByte: begin
            if (collecting_ff) begin
               if (full) begin
                  status_in     = atrc_pkg::StFail;
                  collecting_in = 1'b0;
                  done          = 1'b1;
               end else begin
                  wr.en     = 1'b1;
                  count_in  = count_ff + 1'b1;
                  recent_in = {recent_ff[39:0], rx_byte};
                  if (ok_seen) begin
                     status_in     = atrc_pkg::StOk;
                     collecting_in = 1'b0;
                     done          = 1'b1;
                  end else if (error_seen) begin
                     status_in     = atrc_pkg::StError;
                     collecting_in = 1'b0;
                     done          = 1'b1;
                  end
               end
            end
         end
         atrc_pkg::ActTick: begin
            if (collecting_ff) begin
               ticks_in = ticks_dec;
               if (ticks_dec == '0) begin
                  collecting_in = 1'b0;
                  done          = 1'b1;
               end
            end
         end
         atrc_pkg::ActRead: begin
         end
         default: begin
         end
      endcase
      wr.en = wr.en & item_valid;
   end

   assign rd.en   = item_valid;
   assign rd.addr = atrc_pkg::AddrWidth'(read_index);

   assign result.busy     = collecting_in;
   assign result.status   = status_in;
   assign result.done     = done;
   assign result.count    = count_in;
   assign result.rd_valid = (action == atrc_pkg::ActRead)
      && (32'(read_index) < 32'(atrc_pkg::BufferDepth));

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff     <= '0;
         count_ff      <= '0;
         collecting_ff <= 1'b0;
         status_ff     <= atrc_pkg::StFail;
         ticks_ff      <= '0;
      end else if (item_valid) begin
         recent_ff     <= recent_in;
         count_ff      <= count_in;
         collecting_ff <= collecting_in;
         status_ff     <= status_in;
         ticks_ff      <= ticks_in;
      end
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      item_valid && result.done |-> !result.busy)
      else $error("collection ended but still busy");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(atrc_pkg::BufferDepth))
      else $error("stored count beyond buffer depth");

   a_idle_count_holds: assert property (@(posedge clock) disable iff (reset)
      item_valid && !collecting_ff && action != atrc_pkg::ActArm |=> $stable(count_ff))
      else $error("count moved while not collecting");

   a_write_only_collecting: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> collecting_ff && !full)
      else $error("buffer write outside collection");

endmodule

// ===== design/at_response_collector_top.sv =====
`timescale 1ns / 1ps

// Modem reply collector.
// Input channel req_*: one beat per item; req_tuser carries the action
// (arm, received byte, millisecond tick, read stored byte), req_tdata the
// byte, timeout and read index. Result channel rsp_*: exactly one beat per
// input beat, in order; rsp_tlast is high on the beat that ends collection
// (OK or ERROR terminator seen, buffer overflow, timeout, or zero timeout).
// The result of a beat is registered and offered in the cycle after the
// beat is accepted. Throughput: one beat per cycle while rsp_tready is
// high; state updates in a single pass and the reply buffer has one write
// and one registered read port. When rsp_tready is low the result stays in
// the output register and req_tready drops until it is taken; a waiting
// result does not block a new beat in the cycle it is taken.
// Reset (synchronous) clears length, status to fail, timeout and the
// collecting flag. Buffer contents are not cleared; only bytes below
// byte_count are meaningful.

module at_response_collector_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // rx_byte[7:0], timeout_ticks[23:8], read_index[35:24]
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // busy_res[0], status[2:1], byte_count[15:3], read_data[23:16]
   output logic        rsp_tlast    // done_res
);

   logic                         accept;
   logic                         out_valid_ff, out_valid_in;
   atrc_pkg::result_type         out_res_ff;
   atrc_pkg::result_type         result;
   atrc_pkg::wr_port_type        wr;
   atrc_pkg::rd_port_type        rd;
   logic [7:0]                   rd_data;
   logic [7:0]                   read_data;

   assign req_tready   = !out_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign out_valid_in = accept || (out_valid_ff && !rsp_tready);

   atrc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (accept),
      .action        (atrc_pkg::action_type'(req_tuser)),
      .rx_byte       (req_tdata[7:0]),
      .timeout_ticks (req_tdata[23:8]),
      .read_index    (req_tdata[35:24]),
      .result        (result),
      .wr            (wr),
      .rd            (rd)
   );

   atrc_buffer u_buffer (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_res_ff <= result;
      end
   end

   assign read_data  = out_res_ff.rd_valid ? rd_data : 8'd0;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_res_ff.done;
   assign rsp_tdata  = {read_data,
                        atrc_pkg::ByteCountWidth'(out_res_ff.count),
                        out_res_ff.status,
                        out_res_ff.busy};

endmodule
